// ----- rtl/core/b64_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, character constants and alphabet lookup for the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;

  typedef enum logic [1:0] {
    QPOS_FIRST  = 2'd0,
    QPOS_SECOND = 2'd1,
    QPOS_THIRD  = 2'd2,
    QPOS_FOURTH = 2'd3
  } qpos_e;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // results caused by one request: data bytes first, then optional status
  typedef struct packed {
    logic [1:0] n_data;
    logic       status;
    logic       ok;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } bundle_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CharPlus) begin
      s.value = SextetPlus;
    end else if (c == CharSlash) begin
      s.value = SextetSlash;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

endpackage

// ----- rtl/core/b64_dec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_dec
// Quartet tracker: holds the decode state and forms the results of one
// request in a single pass.
// ----------------------------------------------------------------------------
module b64_dec (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        ch_i,
  input  logic              end_of_text_i,
  output b64_pkg::bundle_t  bundle_o
);

  b64_pkg::qpos_e   pos_q, pos_d;
  logic [5:0]       s0_q, s0_d, s1_q, s1_d, s2_q, s2_d;
  logic             pad_q, pad_d;
  logic             stopped_q, stopped_d;
  logic             failed_q, failed_d;

  b64_pkg::sextet_t sx;
  logic             is_pad;
  logic             pass_stopped, pass_failed;
  b64_pkg::qpos_e   pass_pos;
  logic [1:0]       n_data;

  assign sx     = b64_pkg::sextet_of(ch_i);
  assign is_pad = (ch_i == b64_pkg::CharPad);

  // next state
  always_comb begin
    pass_pos     = pos_q;
    pass_stopped = stopped_q;
    pass_failed  = failed_q;
    s0_d         = s0_q;
    s1_d         = s1_q;
    s2_d         = s2_q;
    pad_d        = pad_q;
    if (!stopped_q) begin
      unique case (pos_q)
        b64_pkg::QPOS_FIRST: begin
          if (b64_pkg::is_space(ch_i)) begin
            pass_stopped = 1'b1;
          end else if (!sx.valid) begin
            pass_stopped = 1'b1;
            pass_failed  = 1'b1;
          end else begin
            s0_d     = sx.value;
            pass_pos = b64_pkg::QPOS_SECOND;
          end
        end
        b64_pkg::QPOS_SECOND: begin
          if (!sx.valid) begin
            pass_stopped = 1'b1;
            pass_failed  = 1'b1;
          end else begin
            s1_d     = sx.value;
            pass_pos = b64_pkg::QPOS_THIRD;
          end
        end
        b64_pkg::QPOS_THIRD: begin
          if (is_pad) begin
            pad_d    = 1'b1;
            s2_d     = '0;
            pass_pos = b64_pkg::QPOS_FOURTH;
          end else if (!sx.valid) begin
            pass_stopped = 1'b1;
            pass_failed  = 1'b1;
          end else begin
            pad_d    = 1'b0;
            s2_d     = sx.value;
            pass_pos = b64_pkg::QPOS_FOURTH;
          end
        end
        b64_pkg::QPOS_FOURTH: begin
          if (pad_q || is_pad || sx.valid) begin
            pass_pos = b64_pkg::QPOS_FIRST;
            pad_d    = 1'b0;
          end else begin
            pass_stopped = 1'b1;
            pass_failed  = 1'b1;
          end
        end
        default: begin
          pass_pos = pos_q;
        end
      endcase
    end
    pos_d     = pass_pos;
    stopped_d = pass_stopped;
    failed_d  = pass_failed;
    if (end_of_text_i) begin
      pos_d     = b64_pkg::QPOS_FIRST;
      s0_d      = '0;
      s1_d      = '0;
      s2_d      = '0;
      pad_d     = 1'b0;
      stopped_d = 1'b0;
      failed_d  = 1'b0;
    end
  end

  // outputs
  always_comb begin
    n_data = 2'd0;
    if (!stopped_q && pos_q == b64_pkg::QPOS_FOURTH) begin
      priority if (pad_q) begin
        n_data = 2'd1;
      end else if (is_pad) begin
        n_data = 2'd2;
      end else if (sx.valid) begin
        n_data = 2'd3;
      end else begin
        n_data = 2'd0;
      end
    end
    bundle_o.n_data = n_data;
    bundle_o.status = end_of_text_i;
    bundle_o.ok     = !pass_failed && (pass_stopped || pass_pos == b64_pkg::QPOS_FIRST);
    bundle_o.byte0  = {s0_q, s1_q[5:4]};
    bundle_o.byte1  = {s1_q[3:0], s2_q[5:2]};
    bundle_o.byte2  = {s2_q[1:0], sx.value};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= b64_pkg::QPOS_FIRST;
      s0_q      <= '0;
      s1_q      <= '0;
      s2_q      <= '0;
      pad_q     <= 1'b0;
      stopped_q <= 1'b0;
      failed_q  <= 1'b0;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      s0_q      <= s0_d;
      s1_q      <= s1_d;
      s2_q      <= s2_d;
      pad_q     <= pad_d;
      stopped_q <= stopped_d;
      failed_q  <= failed_d;
    end
  end

endmodule

// ----- rtl/core/base64_stream_decoder_top.sv -----
`timescale 1ns / 1ps
// first result of a request in the cycle after acceptance when the output
// stage is idle; otherwise right after the last result of the request ahead
// throughput: one request per cycle; a request's results drive the output one after
// another, and input stalls only while a second result bundle waits
// reset: asynchronous, active low; clears quartet state and both result stages
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder: one character per request, data bytes and an
// end-of-string status delivered one per cycle while out_ready_i is high, from a result register.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] data_byte_o,
  output logic       ok_o,
  output logic       last_o
);

  b64_pkg::bundle_t bundle_new;
  b64_pkg::bundle_t bundle_q, bundle_d;
  b64_pkg::bundle_t hold_q, hold_d;
  logic             bundle_valid_q, bundle_valid_d;
  logic             hold_valid_q, hold_valid_d;
  logic [1:0]       idx_q, idx_d;
  logic [2:0]       total_q, total_new;
  logic             in_acc, out_acc;
  logic             out_free, push;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  b64_dec u_dec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .bundle_o      (bundle_new)
  );

  assign total_new  = {1'b0, bundle_new.n_data} + {2'b00, bundle_new.status};
  assign total_q    = {1'b0, bundle_q.n_data} + {2'b00, bundle_q.status};
  assign in_ready_o = !hold_valid_q;
  assign out_free   = !bundle_valid_q || (out_acc && last_o);
  assign push       = in_acc && (total_new != 3'd0);

  // result selection
  always_comb begin
    out_valid_o = bundle_valid_q;
    last_o      = ({1'b0, idx_q} + 3'd1) == total_q;
    if (idx_q < bundle_q.n_data) begin
      kind_o = 1'b0;
      ok_o   = 1'b0;
      unique case (idx_q)
        2'd0:    data_byte_o = bundle_q.byte0;
        2'd1:    data_byte_o = bundle_q.byte1;
        default: data_byte_o = bundle_q.byte2;
      endcase
    end else begin
      kind_o      = 1'b1;
      ok_o        = bundle_q.ok;
      data_byte_o = '0;
    end
  end

  // output stage and spare bundle
  always_comb begin
    bundle_d       = bundle_q;
    bundle_valid_d = bundle_valid_q;
    idx_d          = idx_q;
    hold_d         = hold_q;
    hold_valid_d   = hold_valid_q;
    if (out_free) begin
      idx_d = '0;
      if (hold_valid_q) begin
        bundle_d       = hold_q;
        bundle_valid_d = 1'b1;
        hold_valid_d   = 1'b0;
      end else if (push) begin
        bundle_d       = bundle_new;
        bundle_valid_d = 1'b1;
      end else begin
        bundle_valid_d = 1'b0;
      end
    end else begin
      if (out_acc) begin
        idx_d = idx_q + 2'd1;
      end
      if (push) begin
        hold_d       = bundle_new;
        hold_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bundle_valid_q <= 1'b0;
      idx_q          <= '0;
      bundle_q       <= '0;
      hold_valid_q   <= 1'b0;
      hold_q         <= '0;
    end else begin
      bundle_valid_q <= bundle_valid_d;
      idx_q          <= idx_d;
      bundle_q       <= bundle_d;
      hold_valid_q   <= hold_valid_d;
      hold_q         <= hold_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !hold_valid_q)
    else $error("pending results overwritten");

  a_hold_behind_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> bundle_valid_q)
    else $error("spare bundle without output bundle");

  a_hold_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_o) |=> (out_valid_o && idx_q == $past(idx_q) + 2'd1))
    else $error("result sequence broken");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> last_o)
    else $error("status not final result");

  a_data_ok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_o) |-> (!ok_o && idx_q < 2'd3))
    else $error("bad data result");
`endif

endmodule

// ----- tb/base64_stream_decoder_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_top_test
// Drives base64 strings, one character per request, into the decoder and
// checks every data byte and end-of-string status against a local decoder
// model. Runs directed corner strings, then random strings under several
// idle and stall mixes, including a long output hold that fills the block.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top_test;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       ok;
    logic       last;
  } decoded_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] ch_i          = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic       kind_o;
  logic [7:0] data_byte_o;
  logic       ok_o;
  logic       last_o;

  base64_stream_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .ok_o         (ok_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder model state
  b64_pkg::qpos_e dec_pos;
  logic [5:0]     dec_s0, dec_s1, dec_s2;
  logic           dec_third_pad, dec_stopped, dec_failed;

  decoded_t expected_results[$];
  int       errors        = 0;
  int       cycle_cnt     = 0;
  int       request_cnt   = 0;
  int       result_cnt    = 0;
  int       string_cnt    = 0;
  int       sender_idle_pct = 0;
  int       stall_pct     = 0;
  int       hold_left     = 0;

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] alphabet_index(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 26)};
    if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 52)};
    if (c == b64_pkg::CharPlus) return {1'b0, b64_pkg::SextetPlus};
    if (c == b64_pkg::CharSlash) return {1'b0, b64_pkg::SextetSlash};
    return 7'h40;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == b64_pkg::CharSpace || (c >= b64_pkg::CharTab && c <= b64_pkg::CharCr);
  endfunction

  task automatic clear_decoder();
    dec_pos       = b64_pkg::QPOS_FIRST;
    dec_s0        = '0;
    dec_s1        = '0;
    dec_s2        = '0;
    dec_third_pad = 1'b0;
    dec_stopped   = 1'b0;
    dec_failed    = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic eot);
    decoded_t   res[$];
    logic [6:0] v;
    v = alphabet_index(c);
    if (!dec_stopped) begin
      case (dec_pos)
        b64_pkg::QPOS_FIRST: begin
          if (is_blank(c)) begin
            dec_stopped = 1'b1;
          end else if (v[6]) begin
            dec_stopped = 1'b1;
            dec_failed  = 1'b1;
          end else begin
            dec_s0  = v[5:0];
            dec_pos = b64_pkg::QPOS_SECOND;
          end
        end
        b64_pkg::QPOS_SECOND: begin
          if (v[6]) begin
            dec_stopped = 1'b1;
            dec_failed  = 1'b1;
          end else begin
            dec_s1  = v[5:0];
            dec_pos = b64_pkg::QPOS_THIRD;
          end
        end
        b64_pkg::QPOS_THIRD: begin
          if (c == b64_pkg::CharPad) begin
            dec_third_pad = 1'b1;
            dec_s2        = '0;
            dec_pos       = b64_pkg::QPOS_FOURTH;
          end else if (v[6]) begin
            dec_stopped = 1'b1;
            dec_failed  = 1'b1;
          end else begin
            dec_third_pad = 1'b0;
            dec_s2        = v[5:0];
            dec_pos       = b64_pkg::QPOS_FOURTH;
          end
        end
        default: begin
          if (dec_third_pad) begin
            res.push_back('{1'b0, {dec_s0, dec_s1[5:4]}, 1'b0, 1'b0});
            dec_pos = b64_pkg::QPOS_FIRST;
          end else if (c == b64_pkg::CharPad) begin
            res.push_back('{1'b0, {dec_s0, dec_s1[5:4]}, 1'b0, 1'b0});
            res.push_back('{1'b0, {dec_s1[3:0], dec_s2[5:2]}, 1'b0, 1'b0});
            dec_pos = b64_pkg::QPOS_FIRST;
          end else if (v[6]) begin
            dec_stopped = 1'b1;
            dec_failed  = 1'b1;
          end else begin
            res.push_back('{1'b0, {dec_s0, dec_s1[5:4]}, 1'b0, 1'b0});
            res.push_back('{1'b0, {dec_s1[3:0], dec_s2[5:2]}, 1'b0, 1'b0});
            res.push_back('{1'b0, {dec_s2[1:0], v[5:0]}, 1'b0, 1'b0});
            dec_pos = b64_pkg::QPOS_FIRST;
          end
          if (dec_pos == b64_pkg::QPOS_FIRST) dec_third_pad = 1'b0;
        end
      endcase
    end
    if (eot) begin
      res.push_back('{1'b1, 8'h00,
                      !dec_failed && (dec_stopped || dec_pos == b64_pkg::QPOS_FIRST),
                      1'b0});
      clear_decoder();
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  // request monitor, model update and result check
  always @(posedge clk_i) begin
    decoded_t exp_res;
    if (!rst_ni) begin
      clear_decoder();
    end else begin
      cycle_cnt++;
      if (cycle_cnt >= CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, expected_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
      if (in_valid_i && in_ready_o) begin
        request_cnt++;
        if (end_of_text_i) string_cnt++;
        decode_char(ch_i, end_of_text_i);
      end
      if (out_valid_o && out_ready_i) begin
        result_cnt++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d data_byte %02h ok %0d last %0d",
                 kind_o, data_byte_o, ok_o, last_o);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (kind_o !== exp_res.kind) begin
            $error("kind: expected %0d, actual %0d", exp_res.kind, kind_o);
            errors++;
          end
          if (data_byte_o !== exp_res.data_byte) begin
            $error("data_byte: expected %02h, actual %02h",
                   exp_res.data_byte, data_byte_o);
            errors++;
          end
          if (ok_o !== exp_res.ok) begin
            $error("ok: expected %0d, actual %0d", exp_res.ok, ok_o);
            errors++;
          end
          if (last_o !== exp_res.last) begin
            $error("last: expected %0d, actual %0d", exp_res.last, last_o);
            errors++;
          end
        end
      end
    end
  end

  // result side: random stalls plus an optional long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // called right after a rising edge; returns right after the request is taken
  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    ch_i          <= c;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_text(input string s, input logic eot_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], eot_at_end && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] random_b64_char();
    int unsigned idx;
    idx = $urandom_range(63);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    return (idx == 62) ? b64_pkg::CharPlus : b64_pkg::CharSlash;
  endfunction

  function automatic logic [7:0] random_blank();
    int unsigned k;
    k = $urandom_range(5);
    return (k == 5) ? b64_pkg::CharSpace : 8'(b64_pkg::CharTab + k);
  endfunction

  // mostly well-formed strings with random content; some broken, some noise
  task automatic send_random_string(output int n_sent);
    logic [7:0]  chars[$];
    int unsigned mode, n_quartets, pos;
    mode       = $urandom_range(99);
    n_quartets = $urandom_range(3);
    for (int q = 0; q < n_quartets; q++) begin
      for (int i = 0; i < 4; i++) chars.push_back(random_b64_char());
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(1) == 0) begin
          chars[chars.size() - 2] = b64_pkg::CharPad;
          chars[chars.size() - 1] = ($urandom_range(1) == 0) ? b64_pkg::CharPad :
                                    8'($urandom_range(255));
        end else begin
          chars[chars.size() - 1] = b64_pkg::CharPad;
        end
      end
    end
    if (mode < 15) begin
      chars.push_back(random_blank());
      repeat ($urandom_range(2)) chars.push_back(8'($urandom_range(255)));
    end else if (mode < 25 && chars.size() > 0) begin
      pos = $urandom_range(chars.size() - 1);
      chars[pos] = ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : random_blank();
    end else if (mode < 33 && chars.size() > 0) begin
      repeat ($urandom_range(1, 3)) chars.push_back(random_b64_char());
    end else if (mode >= 88) begin
      chars.delete();
      repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(255)));
    end
    if (chars.size() == 0) chars.push_back(8'($urandom_range(255)));
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    n_sent = chars.size();
  endtask

  task automatic run_random(input int n_items);
    int sent, n;
    sent = 0;
    while (sent < n_items) begin
      send_random_string(n);
      sent += n;
    end
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    stall_pct       = 0;
    send_text("TWFu", 1'b1);
    send_text("TR=", 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("//+/", 1'b0);
    send_char(b64_pkg::CharTab, 1'b0);
    send_char(8'h00, 1'b1);
    send_text("TW", 1'b1);
    send_char(b64_pkg::CharPad, 1'b1);
    send_text("A=", 1'b1);
    send_text("AB", 1'b0);
    send_char(b64_pkg::CharSpace, 1'b1);
    send_text("09az", 1'b0);
    send_char(8'h80, 1'b1);
    send_char(b64_pkg::CharCr, 1'b1);
  endtask

  task automatic test_streaming();
    sender_idle_pct = 0;
    stall_pct       = 0;
    run_random(50);
  endtask

  task automatic test_sparse_input();
    sender_idle_pct = 87;
    stall_pct       = 0;
    run_random(35);
  endtask

  task automatic test_slow_output();
    sender_idle_pct = 0;
    stall_pct       = 87;
    run_random(35);
  endtask

  task automatic test_both_idle();
    sender_idle_pct = 11;
    stall_pct       = 11;
    run_random(40);
  endtask

  task automatic test_output_hold();
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_left      <= HoldCycles;
    run_random(30);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_streaming();
    test_sparse_input();
    test_slow_output();
    test_both_idle();
    test_output_hold();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d character requests in %0d strings, %0d results checked",
             request_cnt, string_cnt, result_cnt);
    $display("phases: directed, streaming, sparse input, slow output, both idle, hold");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- base64_stream_decoder_top.f -----
rtl/core/b64_pkg.sv
rtl/core/b64_dec.sv
rtl/core/base64_stream_decoder_top.sv
tb/base64_stream_decoder_top_test.sv
